[rtl/tpf_pkg.sv]
// ----------------------------------------------------------------------------
// tpf_pkg
// Types, codes and constants shared by the torsion path fingerprint block.
// ----------------------------------------------------------------------------
package tpf_pkg;

	localparam int WORD_W     = 32;
	localparam int PATH_ATOMS = 4;
	localparam int MAX_BITS   = 18;
	localparam int CNT_W      = 5;

	typedef enum logic [1:0] {
		CMD_LOAD_ATOM = 2'd0,
		CMD_LOAD_BOND = 2'd1,
		CMD_WALK      = 2'd2,
		CMD_CLEAR     = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		REG_ATOM_COUNT = 2'd0,
		REG_RING3_EN   = 2'd1,
		REG_RING4_EN   = 2'd2,
		REG_SPARE      = 2'd3
	} reg_index_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_RANGE = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		KIND_LINEAR = 2'd0,
		KIND_RING3  = 2'd1,
		KIND_RING4  = 2'd2
	} kind_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_BOND_DA,
		ST_BOND_DB,
		ST_BOND_W2,
		ST_WALK_A,
		ST_WALK_E,
		ST_WALK_J,
		ST_SCAN,
		ST_NB,
		ST_NB2,
		ST_FORM,
		ST_R4,
		ST_R4S,
		ST_R4N,
		ST_HSTART,
		ST_HWAIT,
		ST_EMIT,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic  start;
		kind_t job;
	} hash_req_t;

	typedef struct packed {
		logic              done;
		logic [WORD_W-1:0] best;
	} hash_rsp_t;

	// mixing weight of term k times bond value
	function automatic logic [8:0] mix_coef(input logic [1:0] k, input logic [2:0] bond);
		logic [6:0] m;
		unique case (k)
			2'd0: m = 7'd73;
			2'd1: m = 7'd46;
			2'd2: m = 7'd93;
			default: m = 7'd27;
		endcase
		return 9'(m) * 9'(bond);
	endfunction

endpackage

[rtl/tpf_hash.sv]
// ----------------------------------------------------------------------------
// tpf_hash
// Shared multiply-add unit: walks a path in both directions, or every rotation
// of a ring both ways, one term a cycle, and keeps the largest hash.
// ----------------------------------------------------------------------------
module tpf_hash (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  tpf_pkg::hash_req_t                    req,
	input  logic [3:0][tpf_pkg::WORD_W-1:0]       pt,
	input  logic [3:0][2:0]                       pb,
	output tpf_pkg::hash_rsp_t                    rsp
);

	logic                       busy_q;
	logic                       done_q;
	tpf_pkg::kind_t             job_q;
	logic [1:0]                 s_q;
	logic                       rev_q;
	logic [1:0]                 k_q;
	logic [tpf_pkg::WORD_W-1:0] acc_q;
	logic [tpf_pkg::WORD_W-1:0] best_q;

	logic                       n3;
	logic                       last_k;
	logic                       finish;
	logic [2:0]                 x;
	logic [2:0]                 y;
	logic [1:0]                 bi;
	logic [1:0]                 ti;
	logic [tpf_pkg::WORD_W-1:0] term;
	logic [tpf_pkg::WORD_W-1:0] base;
	logic [tpf_pkg::WORD_W-1:0] sum;
	logic [tpf_pkg::WORD_W-1:0] nbest;

	function automatic logic [1:0] modn(input logic [2:0] v, input logic three);
		logic [2:0] r;
		r = v;
		if (three && v >= 3'd3) begin
			r = v - 3'd3;
		end
		return r[1:0];
	endfunction

	always_comb begin
		n3     = (job_q == tpf_pkg::KIND_RING3);
		last_k = (job_q == tpf_pkg::KIND_RING4) ? (k_q == 2'd3) : (k_q == 2'd2);
		x      = {1'b0, s_q} + {1'b0, k_q};
		y      = {1'b0, s_q} + (n3 ? 3'd2 : 3'd3) - {1'b0, k_q};
		if (rev_q) begin
			bi = modn(y, n3);
			ti = bi;
		end else begin
			bi = modn(x, n3);
			ti = modn(x + 3'd1, n3);
		end
		term   = 32'(41'(tpf_pkg::mix_coef(k_q, pb[bi])) * 41'(pt[ti]));
		base   = (k_q == 2'd0) ? pt[s_q] : acc_q;
		sum    = base + term;
		nbest  = (sum > best_q) ? sum : best_q;
		finish = last_k && rev_q &&
			((job_q == tpf_pkg::KIND_LINEAR) || (s_q == (n3 ? 2'd2 : 2'd3)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && finish;
			if (req.start) begin
				busy_q <= 1'b1;
			end else if (busy_q && finish) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			job_q  <= req.job;
			s_q    <= 2'd0;
			rev_q  <= 1'b0;
			k_q    <= 2'd0;
			best_q <= '0;
		end else if (busy_q) begin
			if (!last_k) begin
				acc_q <= sum;
				k_q   <= k_q + 2'd1;
			end else begin
				best_q <= nbest;
				k_q    <= 2'd0;
				if (!rev_q) begin
					rev_q <= 1'b1;
					if (job_q == tpf_pkg::KIND_LINEAR) begin
						s_q <= 2'd3;
					end
				end else begin
					rev_q <= 1'b0;
					s_q   <= s_q + 2'd1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.best = best_q;

endmodule

[rtl/torsion_path_fingerprint.sv]
// ----------------------------------------------------------------------------
// torsion_path_fingerprint
// Molecule adjacency store and depth-first four-atom path fingerprint engine.
// ----------------------------------------------------------------------------
// Input words carry a command: load atom, load bond, walk from an edge, or
// clear adjacency. Each input word yields its fingerprint bits (walks only)
// and then one end marker word with last set, carrying the status.
// Handshake is valid/stall on both sides; in_stall stays high from the word
// being taken until its end marker is loaded into the output register.
// Load atom and clear finish sooner than load bond, which reads both degrees
// and then writes the two neighbour entries. A walk reads the start atom and
// its edge, examines neighbour entries through scan, read and check states,
// returns from the deeper level and forms each complete path. Each bit then
// runs through the shared multiply-add unit, one term a cycle, and is started,
// collected and emitted in turn; each four ring neighbour check reads one
// neighbour entry of the start atom. The single multiplier, one term per
// cycle, sets the walk time.
// Reset clears the configuration and marks every degree zero; atom types,
// include marks and neighbour entries hold nothing until loaded.
// A stalled output word holds; the engine waits until the register frees.
// ----------------------------------------------------------------------------
module torsion_path_fingerprint #(
	parameter int MAX_ATOMS  = 64,
	parameter int MAX_DEGREE = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [6:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [5:0]  atom_index,
	input  logic [31:0] atom_kind,
	input  logic        atom_included,
	input  logic [5:0]  other_atom,
	input  logic [1:0]  bond_order,
	input  logic        bond_aromatic,
	input  logic [1:0]  edge_slot,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        has_bit,
	output logic [31:0] bit_number,
	output logic [1:0]  bit_kind,
	output logic [1:0]  status,
	output logic        last
);

	localparam int AW     = $clog2(MAX_ATOMS);
	localparam int SW     = $clog2(MAX_DEGREE);
	localparam int EW     = AW + SW;
	localparam int EDEPTH = MAX_ATOMS * (2 ** SW);
	localparam int DGW    = $clog2(MAX_DEGREE + 1);
	localparam int LW     = $clog2(MAX_ATOMS + 1);
	localparam int CW     = (LW > 7) ? LW : 7;
	localparam int CMPW   = (DGW > 2) ? DGW : 2;

	// configuration
	logic [6:0] atom_count_q;
	logic       ring3_q;
	logic       ring4_q;

	// stores
	logic [31:0]          type_mem [MAX_ATOMS];
	logic                 incl_mem [MAX_ATOMS];
	logic [DGW-1:0]       deg_mem  [MAX_ATOMS];
	logic [AW-1:0]        nbr_mem  [EDEPTH];
	logic [2:0]           bval_mem [EDEPTH];
	logic [MAX_ATOMS-1:0] dvalid_q;

	logic [31:0]    type_rd_q;
	logic           incl_rd_q;
	logic [DGW-1:0] deg_rd_q;
	logic           dv_rd_q;
	logic [AW-1:0]  nbr_rd_q;
	logic [2:0]     bval_rd_q;

	// sequencer state
	tpf_pkg::state_t  state_q, state_d, ret_q, ret_d;
	tpf_pkg::status_t stat_q, stat_d;
	tpf_pkg::kind_t   hjob_q, hjob_d;
	logic [5:0]       a_q, a_d, b_q, b_d;
	logic [1:0]       slot_q, slot_d;
	logic [2:0]       bv_q, bv_d;
	logic [DGW-1:0]   dega_q, dega_d, degb_q, degb_d;
	logic [DGW-1:0]   deg0_q, deg0_d, deg1_q, deg1_d, deg2_q, deg2_d;
	logic [DGW-1:0]   sl1_q, sl1_d, sl2_q, sl2_d, q4_q, q4_d;
	logic             lvl_q, lvl_d;
	logic [3:0][AW-1:0] p_q, p_d;
	logic [3:0][31:0] pt_q, pt_d;
	logic [3:0][2:0]  pb_q, pb_d;
	logic [AW-1:0]    nb_q, nb_d;
	logic [2:0]       nbv_q, nbv_d;
	logic [31:0]      best_q, best_d;
	logic [tpf_pkg::CNT_W-1:0] bitcnt_q, bitcnt_d;

	// memory access
	logic [AW-1:0]  ard;
	logic [EW-1:0]  erd;
	logic           atom_we;
	logic           deg_we;
	logic [AW-1:0]  deg_wa;
	logic [DGW-1:0] deg_wd;
	logic           nbr_we;
	logic [EW-1:0]  nbr_wa;
	logic [AW-1:0]  nbr_wd;
	logic           dv_clr;

	// output register
	logic        out_valid_q;
	logic        ob_has_q, ob_has_d;
	logic [31:0] ob_num_q, ob_num_d;
	logic [1:0]  ob_kind_q, ob_kind_d;
	logic [1:0]  ob_stat_q, ob_stat_d;
	logic        ob_last_q, ob_last_d;
	logic        out_ld;
	logic        out_free;

	tpf_pkg::hash_req_t hreq;
	tpf_pkg::hash_rsp_t hrsp;

	logic [CW-1:0]  live;
	logic           a_ok;
	logic           b_ok;
	logic [DGW-1:0] deg_val;
	logic [DGW-1:0] cur_sl;
	logic [DGW-1:0] cur_deg;
	logic [AW-1:0]  cur_p;
	logic           seen;

	tpf_hash u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (hreq),
		.pt     (pt_q),
		.pb     (pb_q),
		.rsp    (hrsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			atom_count_q <= '0;
			ring3_q      <= 1'b0;
			ring4_q      <= 1'b0;
		end else if (cfg_we) begin
			unique case (tpf_pkg::reg_index_t'(cfg_index))
				tpf_pkg::REG_ATOM_COUNT: atom_count_q <= cfg_data;
				tpf_pkg::REG_RING3_EN:   ring3_q      <= cfg_data[0];
				tpf_pkg::REG_RING4_EN:   ring4_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		live = (CW'(atom_count_q) > CW'(MAX_ATOMS)) ? CW'(MAX_ATOMS) : CW'(atom_count_q);
		a_ok = CW'(atom_index) < live;
		b_ok = CW'(other_atom) < live;
		deg_val  = dv_rd_q ? deg_rd_q : '0;
		cur_sl   = lvl_q ? sl2_q : sl1_q;
		cur_deg  = lvl_q ? deg2_q : deg1_q;
		cur_p    = lvl_q ? p_q[2] : p_q[1];
		seen     = (nb_q == p_q[0]) || (nb_q == p_q[1]) || (lvl_q && nb_q == p_q[2]);
		out_free = !out_valid_q || !out_stall;
	end

	always_comb begin
		state_d  = state_q;
		ret_d    = ret_q;
		stat_d   = stat_q;
		hjob_d   = hjob_q;
		a_d      = a_q;
		b_d      = b_q;
		slot_d   = slot_q;
		bv_d     = bv_q;
		dega_d   = dega_q;
		degb_d   = degb_q;
		deg0_d   = deg0_q;
		deg1_d   = deg1_q;
		deg2_d   = deg2_q;
		sl1_d    = sl1_q;
		sl2_d    = sl2_q;
		q4_d     = q4_q;
		lvl_d    = lvl_q;
		p_d      = p_q;
		pt_d     = pt_q;
		pb_d     = pb_q;
		nb_d     = nb_q;
		nbv_d    = nbv_q;
		best_d   = best_q;
		bitcnt_d = bitcnt_q;

		ard     = AW'(a_q);
		erd     = '0;
		atom_we = 1'b0;
		deg_we  = 1'b0;
		deg_wa  = AW'(a_q);
		deg_wd  = '0;
		nbr_we  = 1'b0;
		nbr_wa  = '0;
		nbr_wd  = '0;
		dv_clr  = 1'b0;

		out_ld    = 1'b0;
		ob_has_d  = ob_has_q;
		ob_num_d  = ob_num_q;
		ob_kind_d = ob_kind_q;
		ob_stat_d = ob_stat_q;
		ob_last_d = ob_last_q;

		hreq.start = 1'b0;
		hreq.job   = hjob_q;

		unique case (state_q)
			tpf_pkg::ST_IDLE: begin
				if (in_valid) begin
					a_d      = atom_index;
					b_d      = other_atom;
					slot_d   = edge_slot;
					bv_d     = bond_aromatic ? 3'd4 : {1'b0, bond_order};
					stat_d   = tpf_pkg::STAT_OK;
					bitcnt_d = '0;
					state_d  = tpf_pkg::ST_FINISH;
					ard      = AW'(atom_index);
					unique case (tpf_pkg::cmd_t'(cmd))
						tpf_pkg::CMD_LOAD_ATOM: begin
							if (a_ok) begin
								atom_we = 1'b1;
							end else begin
								stat_d = tpf_pkg::STAT_RANGE;
							end
						end
						tpf_pkg::CMD_LOAD_BOND: begin
							if (!a_ok || !b_ok || atom_index == other_atom) begin
								stat_d = tpf_pkg::STAT_RANGE;
							end else begin
								state_d = tpf_pkg::ST_BOND_DA;
							end
						end
						tpf_pkg::CMD_WALK: begin
							if (!a_ok) begin
								stat_d = tpf_pkg::STAT_RANGE;
							end else if (live >= CW'(3) && (live > CW'(3) || ring3_q)) begin
								state_d = tpf_pkg::ST_WALK_A;
							end
						end
						default: begin
							dv_clr = 1'b1;
						end
					endcase
				end
			end
			tpf_pkg::ST_BOND_DA: begin
				dega_d  = deg_val;
				ard     = AW'(b_q);
				state_d = tpf_pkg::ST_BOND_DB;
			end
			tpf_pkg::ST_BOND_DB: begin
				if (dega_q >= DGW'(MAX_DEGREE) || deg_val >= DGW'(MAX_DEGREE)) begin
					stat_d  = tpf_pkg::STAT_FULL;
					state_d = tpf_pkg::ST_FINISH;
				end else begin
					degb_d  = deg_val;
					nbr_we  = 1'b1;
					nbr_wa  = {AW'(a_q), dega_q[SW-1:0]};
					nbr_wd  = AW'(b_q);
					deg_we  = 1'b1;
					deg_wa  = AW'(a_q);
					deg_wd  = dega_q + DGW'(1);
					state_d = tpf_pkg::ST_BOND_W2;
				end
			end
			tpf_pkg::ST_BOND_W2: begin
				nbr_we  = 1'b1;
				nbr_wa  = {AW'(b_q), degb_q[SW-1:0]};
				nbr_wd  = AW'(a_q);
				deg_we  = 1'b1;
				deg_wa  = AW'(b_q);
				deg_wd  = degb_q + DGW'(1);
				state_d = tpf_pkg::ST_FINISH;
			end
			tpf_pkg::ST_WALK_A: begin
				if (!incl_rd_q || CMPW'(slot_q) >= CMPW'(deg_val)) begin
					state_d = tpf_pkg::ST_FINISH;
				end else begin
					pt_d[0] = type_rd_q;
					p_d[0]  = AW'(a_q);
					deg0_d  = deg_val;
					erd     = {AW'(a_q), SW'(slot_q)};
					state_d = tpf_pkg::ST_WALK_E;
				end
			end
			tpf_pkg::ST_WALK_E: begin
				pb_d[0] = bval_rd_q;
				nb_d    = nbr_rd_q;
				ard     = nbr_rd_q;
				if (CW'(nbr_rd_q) >= live) begin
					state_d = tpf_pkg::ST_FINISH;
				end else begin
					state_d = tpf_pkg::ST_WALK_J;
				end
			end
			tpf_pkg::ST_WALK_J: begin
				if (!incl_rd_q) begin
					state_d = tpf_pkg::ST_FINISH;
				end else begin
					p_d[1]  = nb_q;
					pt_d[1] = type_rd_q;
					deg1_d  = deg_val;
					sl1_d   = '0;
					lvl_d   = 1'b0;
					state_d = tpf_pkg::ST_SCAN;
				end
			end
			tpf_pkg::ST_SCAN: begin
				if (cur_sl >= cur_deg) begin
					if (lvl_q) begin
						lvl_d = 1'b0;
					end else begin
						state_d = tpf_pkg::ST_FINISH;
					end
				end else begin
					erd     = {cur_p, cur_sl[SW-1:0]};
					state_d = tpf_pkg::ST_NB;
				end
			end
			tpf_pkg::ST_NB: begin
				nb_d  = nbr_rd_q;
				nbv_d = bval_rd_q;
				ard   = nbr_rd_q;
				if (CW'(nbr_rd_q) >= live) begin
					if (lvl_q) begin
						sl2_d = sl2_q + DGW'(1);
					end else begin
						sl1_d = sl1_q + DGW'(1);
					end
					state_d = tpf_pkg::ST_SCAN;
				end else begin
					state_d = tpf_pkg::ST_NB2;
				end
			end
			tpf_pkg::ST_NB2: begin
				if (lvl_q) begin
					sl2_d = sl2_q + DGW'(1);
				end else begin
					sl1_d = sl1_q + DGW'(1);
				end
				state_d = tpf_pkg::ST_SCAN;
				if (incl_rd_q) begin
					if (seen) begin
						if (lvl_q && nb_q != p_q[1] && ring3_q) begin
							pb_d[2] = nbv_q;
							hjob_d  = tpf_pkg::KIND_RING3;
							ret_d   = tpf_pkg::ST_SCAN;
							state_d = tpf_pkg::ST_HSTART;
						end
					end else if (!lvl_q) begin
						pb_d[1] = nbv_q;
						p_d[2]  = nb_q;
						pt_d[2] = type_rd_q;
						deg2_d  = deg_val;
						sl2_d   = '0;
						lvl_d   = 1'b1;
					end else begin
						pb_d[2] = nbv_q;
						p_d[3]  = nb_q;
						pt_d[3] = type_rd_q;
						state_d = tpf_pkg::ST_FORM;
					end
				end
			end
			tpf_pkg::ST_FORM: begin
				if (pt_q[0] <= pt_q[3]) begin
					hjob_d  = tpf_pkg::KIND_LINEAR;
					ret_d   = tpf_pkg::ST_R4;
					state_d = tpf_pkg::ST_HSTART;
				end else begin
					state_d = tpf_pkg::ST_R4;
				end
			end
			tpf_pkg::ST_R4: begin
				q4_d    = '0;
				state_d = ring4_q ? tpf_pkg::ST_R4S : tpf_pkg::ST_SCAN;
			end
			tpf_pkg::ST_R4S: begin
				if (q4_q >= deg0_q) begin
					state_d = tpf_pkg::ST_SCAN;
				end else begin
					erd     = {p_q[0], q4_q[SW-1:0]};
					state_d = tpf_pkg::ST_R4N;
				end
			end
			tpf_pkg::ST_R4N: begin
				if (nbr_rd_q == p_q[3]) begin
					pb_d[3] = bval_rd_q;
					hjob_d  = tpf_pkg::KIND_RING4;
					ret_d   = tpf_pkg::ST_SCAN;
					state_d = tpf_pkg::ST_HSTART;
				end else begin
					q4_d    = q4_q + DGW'(1);
					state_d = tpf_pkg::ST_R4S;
				end
			end
			tpf_pkg::ST_HSTART: begin
				hreq.start = 1'b1;
				state_d    = tpf_pkg::ST_HWAIT;
			end
			tpf_pkg::ST_HWAIT: begin
				if (hrsp.done) begin
					best_d  = hrsp.best;
					state_d = tpf_pkg::ST_EMIT;
				end
			end
			tpf_pkg::ST_EMIT: begin
				if (bitcnt_q >= tpf_pkg::CNT_W'(tpf_pkg::MAX_BITS)) begin
					state_d = ret_q;
				end else if (out_free) begin
					out_ld    = 1'b1;
					ob_has_d  = 1'b1;
					ob_num_d  = best_q;
					ob_kind_d = hjob_q;
					ob_stat_d = tpf_pkg::STAT_OK;
					ob_last_d = 1'b0;
					bitcnt_d  = bitcnt_q + tpf_pkg::CNT_W'(1);
					state_d   = ret_q;
				end
			end
			tpf_pkg::ST_FINISH: begin
				if (out_free) begin
					out_ld    = 1'b1;
					ob_has_d  = 1'b0;
					ob_num_d  = '0;
					ob_kind_d = tpf_pkg::KIND_LINEAR;
					ob_stat_d = stat_q;
					ob_last_d = 1'b1;
					state_d   = tpf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tpf_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tpf_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			bitcnt_q    <= '0;
		end else begin
			state_q  <= state_d;
			bitcnt_q <= bitcnt_d;
			if (out_ld) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		ret_q     <= ret_d;
		stat_q    <= stat_d;
		hjob_q    <= hjob_d;
		a_q       <= a_d;
		b_q       <= b_d;
		slot_q    <= slot_d;
		bv_q      <= bv_d;
		dega_q    <= dega_d;
		degb_q    <= degb_d;
		deg0_q    <= deg0_d;
		deg1_q    <= deg1_d;
		deg2_q    <= deg2_d;
		sl1_q     <= sl1_d;
		sl2_q     <= sl2_d;
		q4_q      <= q4_d;
		lvl_q     <= lvl_d;
		p_q       <= p_d;
		pt_q      <= pt_d;
		pb_q      <= pb_d;
		nb_q      <= nb_d;
		nbv_q     <= nbv_d;
		best_q    <= best_d;
		ob_has_q  <= ob_has_d;
		ob_num_q  <= ob_num_d;
		ob_kind_q <= ob_kind_d;
		ob_stat_q <= ob_stat_d;
		ob_last_q <= ob_last_d;
	end

	// degree valid bits: clear marks every degree zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dvalid_q <= '0;
			dv_rd_q  <= 1'b0;
		end else begin
			dv_rd_q <= dvalid_q[ard];
			if (dv_clr) begin
				dvalid_q <= '0;
			end else if (deg_we) begin
				dvalid_q[deg_wa] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (atom_we) begin
			type_mem[AW'(atom_index)] <= atom_kind;
			incl_mem[AW'(atom_index)] <= atom_included;
		end
		type_rd_q <= type_mem[ard];
		incl_rd_q <= incl_mem[ard];
	end

	always_ff @(posedge clk) begin
		if (deg_we) begin
			deg_mem[deg_wa] <= deg_wd;
		end
		deg_rd_q <= deg_mem[ard];
	end

	always_ff @(posedge clk) begin
		if (nbr_we) begin
			nbr_mem[nbr_wa]  <= nbr_wd;
			bval_mem[nbr_wa] <= bv_q;
		end
		nbr_rd_q  <= nbr_mem[erd];
		bval_rd_q <= bval_mem[erd];
	end

	assign in_stall   = (state_q != tpf_pkg::ST_IDLE);
	assign out_valid  = out_valid_q;
	assign has_bit    = ob_has_q;
	assign bit_number = ob_num_q;
	assign bit_kind   = ob_kind_q;
	assign status     = ob_stat_q;
	assign last       = ob_last_q;

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("engine ready straight after taking a word");

	a_bit_word_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && has_bit |-> status == tpf_pkg::STAT_OK && !last)
		else $error("bit word carries status or last");

	a_hash_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		hrsp.done |-> state_q == tpf_pkg::ST_HWAIT)
		else $error("hash result with nobody waiting");

	a_bit_limit: assert property (@(posedge clk) disable iff (!arst_n)
		bitcnt_q <= tpf_pkg::CNT_W'(tpf_pkg::MAX_BITS))
		else $error("bit count beyond limit");

endmodule

[tb/tb_torsion_path_fingerprint.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_torsion_path_fingerprint
// Self-checking bench for the torsion path fingerprint engine.
// ----------------------------------------------------------------------------
// A queue of command words (atom and bond loads, walks, clears) feeds a
// bursty driver. Every accepted word runs through a local path-enumeration
// predictor that keeps its own copy of the adjacency store and produces the
// expected bit words and end marker. A monitor under a varying stall pattern
// checks every result word against the oldest expectation. Register changes
// happen only once the engine has drained.
// ----------------------------------------------------------------------------
module tb_torsion_path_fingerprint;

	typedef struct {
		logic [1:0]  op;
		logic [5:0]  idx;
		logic [31:0] kind;
		logic        incl;
		logic [5:0]  other;
		logic [1:0]  order;
		logic        arom;
		logic [1:0]  slot;
	} cmd_word_t;

	typedef struct {
		logic             has;
		logic [31:0]      num;
		tpf_pkg::kind_t   kind;
		tpf_pkg::status_t st;
		logic             lst;
	} fp_word_t;

	localparam logic [31:0] MIXW [4] = '{32'd73, 32'd46, 32'd93, 32'd27};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = tpf_pkg::REG_ATOM_COUNT;
	logic [6:0]  cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  cmd = tpf_pkg::CMD_LOAD_ATOM;
	logic [5:0]  atom_index = '0;
	logic [31:0] atom_kind = '0;
	logic        atom_included = 1'b0;
	logic [5:0]  other_atom = '0;
	logic [1:0]  bond_order = '0;
	logic        bond_aromatic = 1'b0;
	logic [1:0]  edge_slot = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        has_bit;
	logic [31:0] bit_number;
	logic [1:0]  bit_kind;
	logic [1:0]  status;
	logic        last;

	torsion_path_fingerprint dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// predictor state
	logic [6:0]  atom_count_q = '0;
	logic        ring3_q = 1'b0;
	logic        ring4_q = 1'b0;
	logic [31:0] kinds [64];
	logic        incl_q [64];
	logic [2:0]  deg [64];
	logic [5:0]  nbr [256];
	logic [2:0]  bval [256];
	logic [31:0] pt [4];
	logic [31:0] pb [4];
	int          live;
	int          nbits;
	int          start_at;

	cmd_word_t pend_q [$];
	fp_word_t  fp_q [$];
	cmd_word_t cur;
	int errors = 0, words_in = 0, words_out = 0, bits_out = 0;

	function automatic logic usable(input int a);
		return a < live && incl_q[a];
	endfunction

	function automatic void add_bit(input logic [31:0] v, input tpf_pkg::kind_t k);
		if (nbits < tpf_pkg::MAX_BITS) begin
			fp_q.push_back('{1'b1, v, k, tpf_pkg::STAT_OK, 1'b0});
			nbits++;
		end
	endfunction

	function automatic logic [31:0] ring_best(input int n);
		logic [31:0] best, h;
		int b, t;
		best = '0;
		for (int s = 0; s < n; s++)
			for (int r = 0; r < 2; r++) begin
				h = pt[s];
				for (int k = 0; k < n; k++) begin
					if (r == 0) begin
						b = (s + k) % n;
						t = (s + k + 1) % n;
					end else begin
						b = (s + n - k - 1) % n;
						t = b;
					end
					h += MIXW[k] * pb[b] * pt[t];
				end
				if (h > best) best = h;
			end
		return best;
	endfunction

	function automatic void close_path(input int m);
		logic [31:0] f, r;
		if (pt[0] <= pt[3]) begin
			f = pt[0] + MIXW[0] * pb[0] * pt[1] + MIXW[1] * pb[1] * pt[2]
				+ MIXW[2] * pb[2] * pt[3];
			r = pt[3] + MIXW[0] * pb[2] * pt[2] + MIXW[1] * pb[1] * pt[1]
				+ MIXW[2] * pb[0] * pt[0];
			add_bit(f > r ? f : r, tpf_pkg::KIND_LINEAR);
		end
		if (ring4_q)
			for (int s = 0; s < deg[start_at]; s++)
				if (nbr[start_at*4+s] == m) begin
					pb[3] = bval[start_at*4+s];
					add_bit(ring_best(4), tpf_pkg::KIND_RING4);
					break;
				end
	endfunction

	function automatic void walk_paths(input int a, input int slot);
		logic [63:0] seenv;
		int e, j, k, m;
		e = a*4 + slot;
		j = nbr[e];
		if (!usable(j)) return;
		seenv = '0;
		seenv[a] = 1'b1;
		seenv[j] = 1'b1;
		start_at = a;
		pt[0] = kinds[a];
		pb[0] = bval[e];
		pt[1] = kinds[j];
		for (int s1 = 0; s1 < deg[j]; s1++) begin
			k = nbr[j*4+s1];
			if (!usable(k) || seenv[k]) continue;
			pb[1] = bval[j*4+s1];
			seenv[k] = 1'b1;
			pt[2] = kinds[k];
			for (int s2 = 0; s2 < deg[k]; s2++) begin
				m = nbr[k*4+s2];
				if (!usable(m)) continue;
				if (seenv[m]) begin
					if (m != j && ring3_q) begin
						pb[2] = bval[k*4+s2];
						add_bit(ring_best(3), tpf_pkg::KIND_RING3);
					end
					continue;
				end
				pb[2] = bval[k*4+s2];
				pt[3] = kinds[m];
				close_path(m);
			end
			seenv[k] = 1'b0;
		end
	endfunction

	function automatic void predict_word(input cmd_word_t w);
		tpf_pkg::status_t st;
		logic [2:0] v;
		st = tpf_pkg::STAT_OK;
		nbits = 0;
		live = atom_count_q > 64 ? 64 : atom_count_q;
		case (w.op)
			tpf_pkg::CMD_LOAD_ATOM: begin
				if (w.idx >= live) st = tpf_pkg::STAT_RANGE;
				else begin
					kinds[w.idx] = w.kind;
					incl_q[w.idx] = w.incl;
				end
			end
			tpf_pkg::CMD_LOAD_BOND: begin
				if (w.idx >= live || w.other >= live || w.idx == w.other)
					st = tpf_pkg::STAT_RANGE;
				else if (deg[w.idx] >= 4 || deg[w.other] >= 4) st = tpf_pkg::STAT_FULL;
				else begin
					v = w.arom ? 3'd4 : 3'(w.order);
					nbr[w.idx*4+deg[w.idx]] = w.other;
					bval[w.idx*4+deg[w.idx]] = v;
					deg[w.idx]++;
					nbr[w.other*4+deg[w.other]] = w.idx;
					bval[w.other*4+deg[w.other]] = v;
					deg[w.other]++;
				end
			end
			tpf_pkg::CMD_WALK: begin
				if (w.idx >= live) st = tpf_pkg::STAT_RANGE;
				else if (live >= 3 && (live > 3 || ring3_q) && usable(w.idx)
					&& w.slot < deg[w.idx])
					walk_paths(w.idx, w.slot);
			end
			default: for (int i = 0; i < 64; i++) deg[i] = '0;
		endcase
		fp_q.push_back('{1'b0, 32'd0, tpf_pkg::KIND_LINEAR, st, 1'b1});
	endfunction

	// driver: bursts with random gaps
	int burst = 0, gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				predict_word(cur);
				words_in++;
			end
			if (!in_valid || !in_stall) begin
				if (gap > 0) begin
					gap--;
					in_valid <= 1'b0;
				end else if (pend_q.size() > 0) begin
					cur = pend_q.pop_front();
					cmd <= cur.op;
					atom_index <= cur.idx;
					atom_kind <= cur.kind;
					atom_included <= cur.incl;
					other_atom <= cur.other;
					bond_order <= cur.order;
					bond_aromatic <= cur.arom;
					edge_slot <= cur.slot;
					in_valid <= 1'b1;
					if (burst > 0) burst--;
					else begin
						burst = $urandom_range(1, 12);
						gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// monitor with its own stall pattern
	int cyc = 0;
	always @(posedge clk) begin
		fp_word_t e;
		cyc++;
		if (arst_n && out_valid && !out_stall) begin
			words_out++;
			if (has_bit) bits_out++;
			if (fp_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected word: bit %h kind %0d st %0d",
					bit_number, bit_kind, status);
			end else begin
				e = fp_q.pop_front();
				if (has_bit !== e.has || bit_number !== e.num || bit_kind !== e.kind
					|| status !== e.st || last !== e.lst) begin
					errors++;
					if (errors <= 10)
						$display({"mismatch: exp has %b bit %h kind %0d st %0d last %b,",
							" got has %b bit %h kind %0d st %0d last %b"},
							e.has, e.num, e.kind, e.st, e.lst,
							has_bit, bit_number, bit_kind, status, last);
				end
			end
		end
		case ((cyc / 97) % 3)
			0: out_stall <= 1'b0;
			1: out_stall <= 1'($urandom_range(0, 1));
			default: out_stall <= ($urandom_range(0, 3) != 0);
		endcase
	end

	task automatic push_word(input tpf_pkg::cmd_t op, input int a, input logic [31:0] k,
		input int inc, input int b, input int ord, input int ar, input int sl);
		pend_q.push_back('{op, 6'(a), k, inc[0], 6'(b), 2'(ord), ar[0], 2'(sl)});
	endtask

	task automatic drain();
		do @(negedge clk);
		while (pend_q.size() > 0 || in_valid || fp_q.size() > 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input tpf_pkg::reg_index_t r, input int v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= r;
		cfg_data <= 7'(v);
		case (r)
			tpf_pkg::REG_ATOM_COUNT: atom_count_q = 7'(v);
			tpf_pkg::REG_RING3_EN:   ring3_q = v[0];
			tpf_pkg::REG_RING4_EN:   ring4_q = v[0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_round();
		int n;
		n = $urandom_range(4, 12);
		write_reg(tpf_pkg::REG_ATOM_COUNT,
			($urandom_range(0, 3) == 0) ? $urandom_range(13, 127) : n);
		write_reg(tpf_pkg::REG_RING3_EN, $urandom_range(0, 1));
		write_reg(tpf_pkg::REG_RING4_EN, $urandom_range(0, 1));
		push_word(tpf_pkg::CMD_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom);
		for (int i = 0; i < 3; i++)
			push_word(tpf_pkg::CMD_LOAD_ATOM, $urandom_range(0, n-1),
				($urandom_range(0, 1) ? $urandom : $urandom_range(0, 3)),
				int'($urandom_range(0, 7) != 0), $urandom, $urandom, $urandom, $urandom);
		for (int i = 0; i < n + n/2; i++)
			push_word(tpf_pkg::CMD_LOAD_BOND, $urandom_range(0, n-1), $urandom, $urandom,
				$urandom_range(0, n-1), $urandom, int'($urandom_range(0, 3) == 0),
				$urandom);
		for (int i = 0; i < 22; i++)
			if ($urandom_range(0, 9) == 0)
				push_word(tpf_pkg::cmd_t'($urandom_range(0, 2)), $urandom, $urandom,
					$urandom, $urandom, $urandom, $urandom, $urandom);
			else
				push_word(tpf_pkg::CMD_WALK, $urandom_range(0, n-1), $urandom, $urandom,
					$urandom, $urandom, $urandom, $urandom_range(0, 3));
		drain();
	endtask

	initial begin
		for (int i = 0; i < 64; i++) deg[i] = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// empty molecule: everything out of range
		push_word(tpf_pkg::CMD_LOAD_ATOM, 63, '1, 1, 0, 0, 0, 0);
		push_word(tpf_pkg::CMD_WALK, 0, 0, 0, 0, 0, 0, 0);
		drain();

		write_reg(tpf_pkg::REG_ATOM_COUNT, 127);
		write_reg(tpf_pkg::REG_RING3_EN, 1);
		write_reg(tpf_pkg::REG_RING4_EN, 1);
		for (int i = 0; i < 64; i++)
			push_word(tpf_pkg::CMD_LOAD_ATOM, i,
				(i == 0) ? 32'hFFFF_FFFF : (i < 4 ? i : $urandom),
				int'(i != 5), 0, 0, 0, 0);
		push_word(tpf_pkg::CMD_LOAD_ATOM, 4, 32'd0, 1, 0, 0, 0, 0);
		// four ring with a chord, duplicate and excluded neighbour
		push_word(tpf_pkg::CMD_LOAD_BOND, 0, 0, 0, 1, 1, 0, 0);
		push_word(tpf_pkg::CMD_LOAD_BOND, 1, 0, 0, 2, 2, 0, 0);
		push_word(tpf_pkg::CMD_LOAD_BOND, 2, 0, 0, 3, 3, 0, 0);
		push_word(tpf_pkg::CMD_LOAD_BOND, 3, 0, 0, 0, 0, 1, 0);
		push_word(tpf_pkg::CMD_LOAD_BOND, 0, 0, 0, 2, 0, 0, 0);
		push_word(tpf_pkg::CMD_LOAD_BOND, 0, 0, 0, 1, 3, 1, 0);
		push_word(tpf_pkg::CMD_LOAD_BOND, 1, 0, 0, 5, 1, 0, 0);
		push_word(tpf_pkg::CMD_LOAD_BOND, 0, 0, 0, 0, 1, 0, 0);
		push_word(tpf_pkg::CMD_LOAD_BOND, 1, 0, 0, 63, 1, 0, 0);
		push_word(tpf_pkg::CMD_LOAD_BOND, 3, 0, 0, 10, 2, 0, 0);
		for (int s = 0; s < 4; s++) push_word(tpf_pkg::CMD_WALK, 0, 0, 0, 0, 0, 0, s);
		push_word(tpf_pkg::CMD_WALK, 1, 0, 0, 0, 0, 0, 3);
		push_word(tpf_pkg::CMD_WALK, 5, 0, 0, 0, 0, 0, 0);
		push_word(tpf_pkg::CMD_WALK, 2, 0, 0, 0, 0, 0, 3);
		push_word(tpf_pkg::CMD_WALK, 3, 0, 0, 0, 0, 0, 1);
		drain();

		// three atoms: stale neighbours, small molecule with and without rings
		write_reg(tpf_pkg::REG_ATOM_COUNT, 3);
		push_word(tpf_pkg::CMD_WALK, 0, 0, 0, 0, 0, 0, 0);
		push_word(tpf_pkg::CMD_WALK, 2, 0, 0, 0, 0, 0, 1);
		push_word(tpf_pkg::CMD_LOAD_BOND, 0, 0, 0, 63, 1, 0, 0);
		push_word(tpf_pkg::CMD_LOAD_ATOM, 63, 0, 1, 0, 0, 0, 0);
		drain();
		write_reg(tpf_pkg::REG_RING3_EN, 0);
		write_reg(tpf_pkg::REG_RING4_EN, 0);
		push_word(tpf_pkg::CMD_WALK, 0, 0, 0, 0, 0, 0, 0);
		push_word(tpf_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0);
		push_word(tpf_pkg::CMD_WALK, 0, 0, 0, 0, 0, 0, 0);
		drain();
		write_reg(tpf_pkg::REG_ATOM_COUNT, 2);
		push_word(tpf_pkg::CMD_WALK, 1, 0, 0, 0, 0, 0, 0);
		drain();

		for (int r = 0; r < 3; r++) random_round();

		repeat (30) @(posedge clk);
		$display("%0d command words in, %0d result words out, %0d fingerprint bits checked",
			words_in, words_out, bits_out);
		if (errors == 0 && fp_q.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#30_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
